>>> rtl/crp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cache replacement policy package
// Sizes, codes, the per-set state entry and the LFSR step shared by the
// replacement engine.
// ----------------------------------------------------------------------------
package crp_pkg;

   localparam int SETS        = 64;
   localparam int WAYS        = 8;
   localparam int SET_W       = $clog2(SETS);
   localparam int WAY_W       = $clog2(WAYS);
   localparam int LEVELS      = WAY_W;
   localparam int TREE_W      = WAYS - 1;
   localparam int POLICY_W    = 2;
   localparam int LFSR_W      = 16;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

   typedef enum logic [POLICY_W-1:0] {
      POL_RANDOM   = 2'd0,
      POL_LRU      = 2'd1,
      POL_PLRU     = 2'd2,
      POL_RESERVED = 2'd3
   } policy_type;

   typedef enum logic {
      OP_VICTIM = 1'b0,
      OP_ACCESS = 1'b1
   } opcode_type;

   // Recency stack, position 0 (the head, least recently used) in the lowest bits.
   typedef logic [WAYS-1:0][WAY_W-1:0] stack_type;

   typedef struct packed {
      logic [TREE_W-1:0] tree;
      stack_type         stack;
   } entry_type;

   function automatic stack_type stack_reset_value();
      stack_type s;
      for (int p = 0; p < WAYS; p++) begin
         s[p] = WAY_W'(p);
      end
      return s;
   endfunction

   // Fibonacci step: taps 0, 2, 3 and 5 feed bit 15.
   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
      logic fb;
      fb = l[0] ^ l[2] ^ l[3] ^ l[5];
      return {fb, l[LFSR_W-1:1]};
   endfunction

endpackage : crp_pkg
`default_nettype wire

>>> rtl/cache_replacement_policy.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cache replacement policy engine
// Chooses victim ways and tracks accesses for a set-associative cache under
// random, true LRU or tree pseudo-LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_*: req_tuser carries the opcode (victim request or
//   access report), req_tdata the set and, for accesses, the way. A victim
//   request returns one response on rsp_* with the chosen way and the set;
//   an access report returns nothing and updates the set's state.
//   csr_we/csr_wdata write the policy register; write it only while idle.
//   A victim response is formed in the second stage and held in the output
//   register until it is taken. One request is taken every cycle while the
//   second stage is not stalled: the set is read from the state memories,
//   then the answer is formed and the modified entry written back. A write
//   to the set read in the same cycle is forwarded, so back-to-back requests
//   to one set see each other.
//   Reset sets the policy to tree pseudo-LRU and the LFSR to its seed; per-set
//   valid bits make every set read as its reset state at once, with no
//   clearing pass. When rsp_tready is low, one response waits in the output
//   register and one more victim request waits in the second stage; after
//   that req_tready drops.
// ----------------------------------------------------------------------------
module cache_replacement_policy (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [5:0] set_sel, [8:6] way, [15:9] zero
   input  wire  [crp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] opcode
   input  wire  [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // [2:0] victim_way, [8:3] victim_set, [15:9] zero
   output logic [crp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire                               csr_we,
   input  wire  [crp_pkg::POLICY_W-1:0]      csr_wdata
);
   import crp_pkg::*;

   policy_type         policy_ff;
   logic [LFSR_W-1:0]  lfsr_ff;
   logic [LFSR_W-1:0]  lfsr_in;
   logic [LFSR_W-1:0]  lfsr_next;

   logic               req_accept;
   logic [SET_W-1:0]   req_set;
   logic [WAY_W-1:0]   req_way;
   opcode_type         req_op;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   opcode_type         s1_op_ff;
   logic [SET_W-1:0]   s1_set_ff;
   logic [WAY_W-1:0]   s1_way_ff;
   logic               s1_done;

   logic               byp_ff;
   logic               byp_in;
   entry_type          byp_data_ff;

   entry_type          mem_entry;
   entry_type          s1_entry;
   entry_type          wr_entry;
   logic               wr_req;
   logic               wr_en;
   logic [WAY_W-1:0]   victim;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [WAY_W-1:0]   rsp_way_ff;
   logic [SET_W-1:0]   rsp_set_ff;
   logic               rsp_load;

   assign req_set    = req_tdata[SET_W-1:0];
   assign req_way    = req_tdata[SET_W+WAY_W-1:SET_W];
   assign req_op     = opcode_type'(req_tuser[0]);
   assign req_accept = req_tvalid && req_tready;

   // An access never waits on the output; a victim request waits for room.
   assign s1_done    = s1_valid_ff && ((s1_op_ff == OP_ACCESS) || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_done;
   assign wr_en      = s1_done && wr_req;
   assign rsp_load   = s1_done && (s1_op_ff == OP_VICTIM);

   crp_state_mem u_state_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_set),
      .wr_en    (wr_en),
      .wr_addr  (s1_set_ff),
      .wr_data  (wr_entry),
      .rd_entry (mem_entry)
   );

   // The memory returns the old entry when it is written in the cycle it is read.
   assign byp_in   = wr_en && (s1_set_ff == req_set);
   assign s1_entry = byp_ff ? byp_data_ff : mem_entry;

   assign lfsr_next = lfsr_step(lfsr_ff);

   crp_policy_unit u_policy_unit (
      .policy    (policy_ff),
      .opcode    (s1_op_ff),
      .way       (s1_way_ff),
      .entry     (s1_entry),
      .lfsr_next (lfsr_next),
      .victim    (victim),
      .wr_req    (wr_req),
      .wr_entry  (wr_entry)
   );

   always_comb begin
      lfsr_in = lfsr_ff;
      if (rsp_load && (policy_ff == POL_RANDOM)) begin
         lfsr_in = lfsr_next;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POL_PLRU;
         lfsr_ff      <= LFSR_SEED;
         s1_valid_ff  <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            policy_ff <= policy_type'(csr_wdata);
         end
         lfsr_ff      <= lfsr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            byp_ff <= byp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= req_op;
         s1_set_ff   <= req_set;
         s1_way_ff   <= req_way;
         byp_data_ff <= wr_entry;
      end
      if (rsp_load) begin
         rsp_way_ff <= victim;
         rsp_set_ff <= s1_set_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - SET_W - WAY_W)'(0), rsp_set_ff, rsp_way_ff};

   // A same-set write in the read cycle must be forwarded to the next request.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && byp_in |=> byp_ff)
      else $error("forwarding flag not set after same-set write");

   // A stalled second stage keeps its request.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_done |=> s1_valid_ff && $stable(s1_set_ff) && $stable(s1_op_ff))
      else $error("second stage lost its request while stalled");

   // A waiting response is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !rsp_load)
      else $error("pending response overwritten");

   // The LFSR never locks up at zero.
   assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("LFSR reached the all-zero state");

endmodule : cache_replacement_policy
`default_nettype wire

>>> rtl/crp_state_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Replacement state store
// Two synchronous memories (tree bits and recency stacks) with registered
// reads, plus a valid bit per set so that untouched sets read as their reset
// state.
// ----------------------------------------------------------------------------
module crp_state_mem (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         rd_en,
   input  wire  [crp_pkg::SET_W-1:0]   rd_addr,
   input  wire                         wr_en,
   input  wire  [crp_pkg::SET_W-1:0]   wr_addr,
   input  wire  crp_pkg::entry_type    wr_data,
   output crp_pkg::entry_type          rd_entry
);
   import crp_pkg::*;

   logic [TREE_W-1:0] tree_mem  [SETS];
   stack_type         stack_mem [SETS];
   logic [SETS-1:0]   valid_ff;
   logic [SETS-1:0]   valid_in;

   logic [TREE_W-1:0] tree_rd_ff;
   stack_type         stack_rd_ff;
   logic              valid_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem[wr_addr]  <= wr_data.tree;
         stack_mem[wr_addr] <= wr_data.stack;
      end
      if (rd_en) begin
         tree_rd_ff  <= tree_mem[rd_addr];
         stack_rd_ff <= stack_mem[rd_addr];
         valid_rd_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      if (valid_rd_ff) begin
         rd_entry.tree  = tree_rd_ff;
         rd_entry.stack = stack_rd_ff;
      end else begin
         rd_entry.tree  = '0;
         rd_entry.stack = stack_reset_value();
      end
   end

endmodule : crp_state_mem
`default_nettype wire

>>> rtl/crp_policy_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Replacement policy unit
// Picks the victim for a set and computes the updated entry after an access,
// for random, true LRU and tree pseudo-LRU.
// ----------------------------------------------------------------------------
module crp_policy_unit (
   input  wire  crp_pkg::policy_type   policy,
   input  wire  crp_pkg::opcode_type   opcode,
   input  wire  [crp_pkg::WAY_W-1:0]   way,
   input  wire  crp_pkg::entry_type    entry,
   input  wire  [crp_pkg::LFSR_W-1:0]  lfsr_next,
   output logic [crp_pkg::WAY_W-1:0]   victim,
   output logic                        wr_req,
   output crp_pkg::entry_type          wr_entry
);
   import crp_pkg::*;

   logic [WAY_W-1:0]  plru_way;
   logic [WAY_W-1:0]  walk_idx;
   logic [WAY_W-1:0]  touch_idx;
   logic [TREE_W-1:0] tree_new;
   stack_type         stack_new;
   logic              seen;

   // Tree walk: the victim is built from the node bits met on the way down,
   // most significant bit first.
   always_comb begin
      plru_way = '0;
      walk_idx = '0;
      for (int l = 0; l < LEVELS; l++) begin
         walk_idx = WAY_W'((1 << l) - 1) + plru_way;
         plru_way = {plru_way[WAY_W-2:0], entry.tree[walk_idx]};
      end
   end

   // Every ancestor of the accessed leaf is made to point away from it.
   always_comb begin
      tree_new  = entry.tree;
      touch_idx = '0;
      for (int l = 0; l < LEVELS; l++) begin
         touch_idx = WAY_W'((1 << l) - 1) + WAY_W'(way >> (LEVELS - l));
         tree_new[touch_idx] = ~way[LEVELS-1-l];
      end
   end

   // Remove the accessed way from the stack, close the gap and put it at the tail.
   always_comb begin
      stack_new = entry.stack;
      seen      = 1'b0;
      for (int p = 0; p < WAYS - 1; p++) begin
         seen = seen | (entry.stack[p] == way);
         stack_new[p] = seen ? entry.stack[p+1] : entry.stack[p];
      end
      stack_new[WAYS-1] = way;
   end

   always_comb begin
      unique case (policy)
         POL_RANDOM:   victim = lfsr_next[WAY_W-1:0];
         POL_LRU:      victim = entry.stack[0];
         POL_PLRU:     victim = plru_way;
         POL_RESERVED: victim = '0;
         default:      victim = '0;
      endcase
   end

   always_comb begin
      wr_req         = (opcode == OP_ACCESS) && ((policy == POL_LRU) || (policy == POL_PLRU));
      wr_entry.tree  = (policy == POL_PLRU) ? tree_new  : entry.tree;
      wr_entry.stack = (policy == POL_LRU)  ? stack_new : entry.stack;
   end

endmodule : crp_policy_unit
`default_nettype wire

>>> dv/cache_replacement_policy_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache replacement policy testbench
// Sends victim requests and access reports under random, true LRU, tree
// pseudo-LRU and the reserved policy code. The sender runs in bursts and the
// receiver stalls on its own pattern. Every victim response is checked against
// a per-set model of the replacement state kept inside this bench.
// ----------------------------------------------------------------------------
module cache_replacement_policy_tb;
   import crp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 6;

   typedef struct packed {
      logic [WAY_W-1:0] victim_way;
      logic [SET_W-1:0] victim_set;
   } victim_answer_type;

   typedef enum {
      RX_STEADY,
      RX_LIGHT,
      RX_HEAVY,
      RX_BLOCKS
   } rx_pattern_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [5:0] set_sel, [8:6] way, [15:9] zero
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // [0] opcode
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [2:0] victim_way, [8:3] victim_set, [15:9] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [POLICY_W-1:0]    csr_wdata  = '0;

   // Replacement state as the bench expects it to be.
   policy_type          active_policy;
   logic [TREE_W-1:0]   tree_model  [SETS];
   stack_type           order_model [SETS];
   logic [LFSR_W-1:0]   lfsr_model;
   logic [WAY_W-1:0]    last_victim_way;
   victim_answer_type   pending_victims [$];

   logic [SET_W-1:0]    hot_sets [4];
   int                  burst_left;
   int                  error_count;
   int                  requests_taken;
   int                  victims_checked;
   int                  requests_per_policy [4];
   int                  idle_cycles;
   int                  stall_span;
   rx_pattern_type      stall_mode;

   cache_replacement_policy dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Applies one accepted request to the model and queues the victim it yields.
   task automatic update_replacement_model(input opcode_type op,
                                           input logic [SET_W-1:0] set_sel,
                                           input logic [WAY_W-1:0] way);
      int node;
      int parent;
      int pos;
      logic [WAY_W-1:0] victim;
      victim_answer_type answer;
      victim = '0;
      requests_per_policy[active_policy]++;
      if (op == OP_VICTIM) begin
         case (active_policy)
            POL_RANDOM: begin
               lfsr_model = {lfsr_model[0] ^ lfsr_model[2] ^ lfsr_model[3] ^ lfsr_model[5],
                             lfsr_model[LFSR_W-1:1]};
               victim = WAY_W'(lfsr_model % WAYS);
            end
            POL_LRU: begin
               victim = order_model[set_sel][0];
            end
            POL_PLRU: begin
               node = 0;
               while (node < TREE_W) begin
                  node = tree_model[set_sel][node] ? 2 * node + 2 : 2 * node + 1;
               end
               victim = WAY_W'(node - TREE_W);
            end
            default: begin
               victim = '0;
            end
         endcase
         last_victim_way   = victim;
         answer.victim_way = victim;
         answer.victim_set = set_sel;
         pending_victims.insert(pending_victims.size(), answer);
      end else if (active_policy == POL_LRU) begin
         pos = 0;
         while (pos < WAYS && order_model[set_sel][pos] != way) pos++;
         while (pos < WAYS - 1) begin
            order_model[set_sel][pos] = order_model[set_sel][pos + 1];
            pos++;
         end
         order_model[set_sel][WAYS-1] = way;
      end else if (active_policy == POL_PLRU) begin
         // Each ancestor points away from the touched leaf: a left child sets 1.
         node = TREE_W + way;
         while (node > 0) begin
            parent = (node - 1) / 2;
            tree_model[set_sel][parent] = node[0];
            node = parent;
         end
      end
   endtask

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic send_request(input opcode_type op, input logic [SET_W-1:0] set_sel,
                               input logic [WAY_W-1:0] way);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({way, set_sel});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      update_replacement_model(op, set_sel, way);
      requests_taken++;
      pace_sender();
   endtask

   // Access reports give no response, so a further wait after the last victim lets the pipeline empty.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (pending_victims.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_policy(input policy_type pol);
      wait_until_drained();
      csr_we    <= 1'b1;
      csr_wdata <= pol;
      @(posedge clock);
      csr_we <= 1'b0;
      active_policy = pol;
   endtask

   task automatic test_plru_directed();
      burst_left = 12;
      send_request(OP_VICTIM, 6'd0, 3'd0);
      send_request(OP_VICTIM, 6'd63, 3'd7);
      send_request(OP_ACCESS, 6'd0, 3'd0);
      send_request(OP_VICTIM, 6'd0, 3'd7);
      send_request(OP_ACCESS, 6'd63, 3'd7);
      send_request(OP_VICTIM, 6'd63, 3'd0);
      // Access and victim on one set back to back exercise the write-back bypass.
      send_request(OP_ACCESS, 6'd42, 3'd5);
      send_request(OP_VICTIM, 6'd42, 3'd2);
   endtask

   task automatic test_lru_directed();
      write_policy(POL_LRU);
      burst_left = 12;
      send_request(OP_VICTIM, 6'd0, 3'd0);
      send_request(OP_ACCESS, 6'd0, 3'd0);
      send_request(OP_VICTIM, 6'd0, 3'd0);
      send_request(OP_ACCESS, 6'd63, 3'd7);
      send_request(OP_ACCESS, 6'd63, 3'd0);
      send_request(OP_VICTIM, 6'd63, 3'd0);
      send_request(OP_VICTIM, 6'd21, 3'd5);
   endtask

   task automatic test_random_policy_directed();
      write_policy(POL_RANDOM);
      burst_left = 8;
      send_request(OP_VICTIM, 6'd0, 3'd0);
      send_request(OP_ACCESS, 6'd0, 3'd3);
      send_request(OP_VICTIM, 6'd63, 3'd7);
      send_request(OP_VICTIM, 6'd0, 3'd0);
   endtask

   task automatic test_reserved_policy();
      write_policy(POL_RESERVED);
      burst_left = 8;
      send_request(OP_VICTIM, 6'd63, 3'd7);
      send_request(OP_ACCESS, 6'd63, 3'd6);
      send_request(OP_VICTIM, 6'd63, 3'd0);
   endtask

   // Mostly miss-then-fill pairs and hits on a few busy sets, with some noise.
   task automatic test_mixed_traffic(input policy_type pol, input int count);
      int sent;
      int pick;
      bit paused;
      logic [SET_W-1:0] set_sel;
      write_policy(pol);
      for (int h = 0; h < 4; h++) hot_sets[h] = SET_W'($urandom_range(0, SETS - 1));
      sent   = 0;
      paused = 1'b0;
      while (sent < count) begin
         set_sel = ($urandom_range(0, 9) < 7) ? hot_sets[$urandom_range(0, 3)]
                                             : SET_W'($urandom_range(0, SETS - 1));
         pick = $urandom_range(0, 19);
         if (pick < 10) begin
            send_request(OP_VICTIM, set_sel, WAY_W'($urandom_range(0, WAYS - 1)));
            send_request(OP_ACCESS, set_sel, last_victim_way);
            sent += 2;
         end else if (pick < 16) begin
            send_request(OP_ACCESS, set_sel, WAY_W'($urandom_range(0, WAYS - 1)));
            sent++;
         end else if (pick < 18) begin
            send_request(OP_VICTIM, set_sel, WAY_W'($urandom_range(0, WAYS - 1)));
            sent++;
         end else begin
            send_request(opcode_type'($urandom_range(0, 1)), SET_W'($urandom_range(0, SETS - 1)),
                         WAY_W'($urandom_range(0, WAYS - 1)));
            sent++;
         end
         if ((!paused && sent >= count / 2) || $urandom_range(0, 79) == 0) begin
            wait_until_drained();
            paused = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : check_responses
      victim_answer_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_victims.size() == 0) begin
            $error("victim response with no request outstanding: way %0d set %0d",
                   rsp_tdata[WAY_W-1:0], rsp_tdata[WAY_W+SET_W-1:WAY_W]);
            error_count++;
         end else begin
            expected = pending_victims.pop_front();
            victims_checked++;
            if (rsp_tdata[WAY_W-1:0] !== expected.victim_way) begin
               $error("victim_way: expected %0d, actual %0d",
                      expected.victim_way, rsp_tdata[WAY_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[WAY_W+SET_W-1:WAY_W] !== expected.victim_set) begin
               $error("victim_set: expected %0d, actual %0d",
                      expected.victim_set, rsp_tdata[WAY_W+SET_W-1:WAY_W]);
               error_count++;
            end
            if (rsp_tdata[RSP_TDATA_W-1:WAY_W+SET_W] !== '0) begin
               $error("rsp_tdata padding: expected 0, actual %0h",
                      rsp_tdata[RSP_TDATA_W-1:WAY_W+SET_W]);
               error_count++;
            end
         end
      end
   end

   // The receiver switches between steady, light, heavy and blocky stalling.
   always @(posedge clock) begin : receiver_pattern
      if (stall_span == 0) begin
         stall_mode = rx_pattern_type'($urandom_range(0, 3));
         stall_span = $urandom_range(16, 96);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         RX_STEADY: rsp_tready <= 1'b1;
         RX_LIGHT:  rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_HEAVY:  rsp_tready <= ($urandom_range(0, 9) < 3);
         default:   rsp_tready <= ((stall_span % 12) < 5);
      endcase
   end

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("no request or response accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("cache_replacement_policy regression: fail");
         $finish;
      end
   end

   initial begin
      active_policy = POL_PLRU;
      lfsr_model    = LFSR_SEED;
      for (int s = 0; s < SETS; s++) begin
         tree_model[s] = '0;
         for (int p = 0; p < WAYS; p++) order_model[s][p] = WAY_W'(p);
      end
      burst_left      = 0;
      error_count     = 0;
      requests_taken  = 0;
      victims_checked = 0;
      idle_cycles     = 0;
      stall_span      = 0;
      stall_mode      = RX_STEADY;
      for (int k = 0; k < 4; k++) requests_per_policy[k] = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_plru_directed();
      test_lru_directed();
      test_random_policy_directed();
      test_reserved_policy();
      test_mixed_traffic(POL_PLRU, 150);
      test_mixed_traffic(POL_LRU, 150);
      test_mixed_traffic(POL_RANDOM, 100);
      test_mixed_traffic(POL_RESERVED, 30);
      // Returning to earlier policies checks that their state survived the switches.
      test_mixed_traffic(POL_PLRU, 60);
      test_mixed_traffic(POL_LRU, 60);
      wait_until_drained();

      $display("Run covered %0d requests and %0d checked victim responses.",
               requests_taken, victims_checked);
      $display("Requests per policy: random %0d, true LRU %0d, tree PLRU %0d, reserved %0d.",
               requests_per_policy[POL_RANDOM], requests_per_policy[POL_LRU],
               requests_per_policy[POL_PLRU], requests_per_policy[POL_RESERVED]);
      if (error_count == 0) begin
         $display("cache_replacement_policy regression: pass");
      end else begin
         $display("cache_replacement_policy regression: fail");
      end
      $finish;
   end

endmodule
